// ----- hdl/palindromic_tree_builder_assert.svh -----
// Assertion macros for the palindromic tree builder checker.
`ifndef PALINDROMIC_TREE_BUILDER_ASSERT_SVH
`define PALINDROMIC_TREE_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptb assertion failed");

// Next-cycle implication, disabled in reset.
`define PTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptb assertion failed");

`endif

// ----- hdl/ptb_pkg.sv -----
// Shared constants and types of the palindromic tree builder.
package ptb_pkg;
    localparam int MAX_TEXT    = 1024;
    localparam int ALPHABET    = 26;
    localparam int NODES       = MAX_TEXT + 2;
    localparam int CHILD_DEPTH = NODES * ALPHABET;
    localparam int LETTER_W    = 5;
    localparam int OUT_W       = 11;
    localparam int TEXT_AW     = $clog2(MAX_TEXT);
    localparam int TLEN_W      = $clog2(MAX_TEXT + 1);
    localparam int NODE_W      = $clog2(NODES);
    localparam int LEN_W       = NODE_W + 1;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_SKIP = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic [1:0]          kind;
    } t_item;
endpackage

// ----- hdl/palindromic_tree_builder.sv -----
// Top level of the palindromic tree builder.
//  channel  dir  handshake          beat
//  letter   in   i_valid / o_stall  i_letter
//  result   out  o_valid / i_stall  o_distinct_palindromes, o_longest_suffix_length,
//                                   o_created_new, o_overflow
// After reset a clearing pass sweeps all 26676 child-table entries; o_stall is high.
// A letter passes S_RDN, S_CHK, S_CMP and S_CHD when the first node tried extends; a walk
// moves to the next node from S_CHK (palindrome too long) or S_CMP (letter mismatch).
// A new node longer than one letter adds a suffix-link walk to find its link.
// Ignored letters go straight to S_OUT; a stalled result holds the back end until it drains.
// A two-beat queue decouples the input from the walks.
module palindromic_tree_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_letter,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_distinct_palindromes,
    output logic [10:0] o_longest_suffix_length,
    output logic        o_created_new,
    output logic        o_overflow
);
    import ptb_pkg::*;

    logic  w_busy, w_head_valid, w_pop;
    t_item w_head;

    ptb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_letter     (i_letter),
        .i_busy       (w_busy),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    ptb_back u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .o_busy                  (w_busy),
        .i_head_valid            (w_head_valid),
        .i_head                  (w_head),
        .o_pop                   (w_pop),
        .o_valid                 (o_valid),
        .i_stall                 (i_stall),
        .o_distinct_palindromes  (o_distinct_palindromes),
        .o_longest_suffix_length (o_longest_suffix_length),
        .o_created_new           (o_created_new),
        .o_overflow              (o_overflow)
    );
endmodule

// ----- hdl/ptb_front.sv -----
// Front end: accepts letters, classifies them and queues them for the back end.
module ptb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [4:0]     i_letter,
    input  logic           i_busy,
    output logic           o_head_valid,
    output ptb_pkg::t_item o_head,
    input  logic           i_pop
);
    import ptb_pkg::*;

    t_item             r_q [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic [TLEN_W-1:0] r_len;
    logic              w_acc;
    t_item             w_item;

    assign o_stall      = (r_cnt == 2'd2) || i_busy;
    assign w_acc        = i_valid && !o_stall;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_comb begin
        w_item.letter = i_letter;
        if (r_len == TLEN_W'(MAX_TEXT)) begin
            w_item.kind = KIND_OVF;
        end else if ({1'b0, i_letter} >= (LETTER_W + 1)'(ALPHABET)) begin
            w_item.kind = KIND_SKIP;
        end else begin
            w_item.kind = KIND_ADD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_len <= '0;
        end else begin
            if (w_acc) begin
                r_wp <= !r_wp;
                if (w_item.kind == KIND_ADD) begin
                    r_len <= r_len + 1'b1;
                end
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, i_pop};
        end
    end
endmodule

// ----- hdl/ptb_back.sv -----
// Back end: tree memories, suffix-link walks, node creation and result register.
module ptb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_busy,
    input  logic              i_head_valid,
    input  ptb_pkg::t_item    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [10:0]       o_distinct_palindromes,
    output logic [10:0]       o_longest_suffix_length,
    output logic              o_created_new,
    output logic              o_overflow
);
    import ptb_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RDN  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_CHD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [LETTER_W-1:0] text_mem  [MAX_TEXT];
    logic [LEN_W-1:0]    nlen_mem  [NODES];
    logic [NODE_W-1:0]   link_mem  [NODES];
    logic [NODE_W-1:0]   child_mem [CHILD_DEPTH];

    logic [LETTER_W-1:0] r_text_rd;
    logic [LEN_W-1:0]    r_nlen_rd;
    logic [NODE_W-1:0]   r_link_rd, r_child_rd;

    logic [2:0]          r_state;
    logic [CHILD_AW-1:0] r_clr;
    logic [TLEN_W-1:0]   r_tlen;
    logic [NODE_W-1:0]   r_ncnt, r_lsn, r_node, r_link, r_fresh;
    logic [LEN_W-1:0]    r_lsn_len, r_len;
    logic [LETTER_W-1:0] r_letter;
    logic                r_pass, r_created, r_ovf;
    logic                r_ovalid;
    logic [OUT_W-1:0]    r_odist, r_olen;
    logic                r_ocre, r_oovf;

    logic [TLEN_W+1:0]   w_pos;
    logic [CHILD_AW-1:0] w_caddr;
    logic [LEN_W-1:0]    w_newlen;
    logic                w_out_free;

    logic                w_text_we;
    logic                w_nlen_we, w_link_we, w_child_we;
    logic [NODE_W-1:0]   w_nlen_wa, w_link_wa, w_link_wd, w_child_wd;
    logic [LEN_W-1:0]    w_nlen_wd;
    logic [CHILD_AW-1:0] w_child_wa;

    assign w_pos = {2'b00, r_tlen} - {{(TLEN_W + 2 - LEN_W){r_nlen_rd[LEN_W-1]}}, r_nlen_rd}
                 - (TLEN_W + 2)'(2);
    assign w_caddr = CHILD_AW'(r_node) * CHILD_AW'(ALPHABET) + CHILD_AW'(r_letter);
    assign w_newlen = r_len + LEN_W'(2);
    assign w_out_free = !r_ovalid || !i_stall;
    assign o_busy = (r_state == S_CLR);
    assign o_pop = (r_state == S_IDLE) && i_head_valid;

    always_comb begin
        w_text_we  = o_pop && (i_head.kind == KIND_ADD);
        w_nlen_we  = 1'b0;
        w_nlen_wa  = r_ncnt;
        w_nlen_wd  = w_newlen;
        w_link_we  = 1'b0;
        w_link_wa  = r_fresh;
        w_link_wd  = r_child_rd;
        w_child_we = 1'b0;
        w_child_wa = w_caddr;
        w_child_wd = r_ncnt;
        case (r_state)
            S_CLR: begin
                w_child_we = 1'b1;
                w_child_wa = r_clr;
                w_child_wd = '0;
                if (r_clr < CHILD_AW'(2)) begin
                    w_nlen_we = 1'b1;
                    w_nlen_wa = NODE_W'(r_clr);
                    w_nlen_wd = (r_clr == '0) ? '1 : '0;
                    w_link_we = 1'b1;
                    w_link_wa = NODE_W'(r_clr);
                    w_link_wd = '0;
                end
            end
            S_CHD: begin
                if (!r_pass && r_child_rd == '0) begin
                    w_nlen_we  = 1'b1;
                    w_child_we = 1'b1;
                    if (r_len == '1) begin
                        w_link_we = 1'b1;
                        w_link_wa = r_ncnt;
                        w_link_wd = NODE_W'(1);
                    end
                end else if (r_pass) begin
                    w_link_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_text_we) begin
            text_mem[r_tlen[TEXT_AW-1:0]] <= i_head.letter;
        end
        r_text_rd <= text_mem[w_pos[TEXT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_nlen_we) begin
            nlen_mem[w_nlen_wa] <= w_nlen_wd;
        end
        r_nlen_rd <= nlen_mem[r_node];
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            link_mem[w_link_wa] <= w_link_wd;
        end
        r_link_rd <= link_mem[r_node];
    end

    always_ff @(posedge i_clk) begin
        if (w_child_we) begin
            child_mem[w_child_wa] <= w_child_wd;
        end
        r_child_rd <= child_mem[w_caddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_tlen    <= '0;
            r_ncnt    <= NODE_W'(2);
            r_lsn     <= NODE_W'(1);
            r_lsn_len <= '0;
            r_ovalid  <= 1'b0;
            r_pass    <= 1'b0;
            r_created <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CHILD_AW'(CHILD_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_letter  <= i_head.letter;
                        r_created <= 1'b0;
                        r_pass    <= 1'b0;
                        r_ovf     <= (i_head.kind == KIND_OVF);
                        if (i_head.kind == KIND_ADD) begin
                            r_tlen  <= r_tlen + 1'b1;
                            r_node  <= r_lsn;
                            r_state <= S_RDN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RDN: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_len  <= r_nlen_rd;
                    r_link <= r_link_rd;
                    if (w_pos[TLEN_W+1]) begin
                        r_node  <= r_link_rd;
                        r_state <= S_RDN;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_text_rd == r_letter) begin
                        r_state <= S_CHD;
                    end else begin
                        r_node  <= r_link;
                        r_state <= S_RDN;
                    end
                end
                S_CHD: begin
                    if (r_pass) begin
                        r_state <= S_OUT;
                    end else if (r_child_rd != '0) begin
                        r_lsn     <= r_child_rd;
                        r_lsn_len <= w_newlen;
                        r_state   <= S_OUT;
                    end else begin
                        r_created <= 1'b1;
                        r_fresh   <= r_ncnt;
                        r_ncnt    <= r_ncnt + 1'b1;
                        r_lsn     <= r_ncnt;
                        r_lsn_len <= w_newlen;
                        if (r_len == '1) begin
                            r_state <= S_OUT;
                        end else begin
                            r_pass  <= 1'b1;
                            r_node  <= r_link;
                            r_state <= S_RDN;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_odist <= OUT_W'(r_ncnt - NODE_W'(2));
            r_olen  <= OUT_W'(r_lsn_len);
            r_ocre  <= r_created;
            r_oovf  <= r_ovf;
        end
    end

    assign o_valid                 = r_ovalid;
    assign o_distinct_palindromes  = r_odist;
    assign o_longest_suffix_length = r_olen;
    assign o_created_new           = r_ocre;
    assign o_overflow              = r_oovf;
endmodule

// ----- hdl/ptb_checker.sv -----
// Port-level checker for the palindromic tree builder, with its bind.
`include "palindromic_tree_builder_assert.svh"

module ptb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [10:0] o_distinct_palindromes,
    input logic [10:0] o_longest_suffix_length,
    input logic        o_created_new,
    input logic        o_overflow
);
    `PTB_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `PTB_ASSERT_NXT(a_hold_count, i_clk, i_rst_n, o_valid && i_stall, $stable(o_distinct_palindromes))
    `PTB_ASSERT_IMP(a_ovf_no_new, i_clk, i_rst_n, o_valid && o_overflow, !o_created_new)
    `PTB_ASSERT_IMP(a_new_counted, i_clk, i_rst_n, o_valid && o_created_new, o_distinct_palindromes != 11'd0)
    `PTB_ASSERT_IMP(a_empty_len, i_clk, i_rst_n, o_valid && o_distinct_palindromes == 11'd0, o_longest_suffix_length == 11'd0)
endmodule

bind palindromic_tree_builder ptb_checker u_ptb_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .o_valid                 (o_valid),
    .i_stall                 (i_stall),
    .o_distinct_palindromes  (o_distinct_palindromes),
    .o_longest_suffix_length (o_longest_suffix_length),
    .o_created_new           (o_created_new),
    .o_overflow              (o_overflow)
);

// ----- verif/palindromic_tree_builder_tb.sv -----
// Testbench for the palindromic tree builder: directed table plus random text, with a predictor.
`timescale 1ns / 1ps

module palindromic_tree_builder_tb;
    import ptb_pkg::*;

    typedef struct packed {
        logic [10:0] distinct;
        logic [10:0] suffix_len;
        logic        created;
        logic        ovf;
    } t_tree_result;

    typedef struct {
        logic [4:0]   letter;
        bit           typed;
        t_tree_result res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_letter;
    logic        o_valid;
    logic        i_stall;
    logic [10:0] o_distinct_palindromes;
    logic [10:0] o_longest_suffix_length;
    logic        o_created_new;
    logic        o_overflow;

    palindromic_tree_builder i_dut (.*);

    // tree model state
    logic [4:0] text_mem [MAX_TEXT];
    int         text_len;
    int         pal_len [NODES];
    int         pal_link [NODES];
    int         pal_child [CHILD_DEPTH];
    int         pal_nodes;
    int         tail_node;

    t_tree_result pending_results[$];
    int           errors;
    int           beats_in;
    int           beats_out;
    int           nodes_made;
    int           overflows;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           draining;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(20ms);
        $display("timeout: %0d results still pending", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic void tree_reset();
        text_len = 0;
        for (int n = 0; n < NODES; n++) begin
            pal_len[n] = 0;
            pal_link[n] = 0;
        end
        for (int c = 0; c < CHILD_DEPTH; c++) pal_child[c] = 0;
        pal_len[0] = -1;
        pal_nodes = 2;
        tail_node = 1;
    endfunction

    function automatic int clip_node(int n);
        return (n >= 0 && n < NODES) ? n : 0;
    endfunction

    function automatic int find_extendable(int start, int letter);
        int n;
        int pos;
        n = start;
        for (int g = 0; g <= NODES; g++) begin
            n = clip_node(n);
            pos = text_len - pal_len[n] - 2;
            if (pos >= 0 && pos < text_len && text_mem[pos] == letter) return n;
            n = pal_link[n];
        end
        return 0;
    endfunction

    function automatic t_tree_result tree_status(bit created, bit ovf);
        t_tree_result r;
        r.distinct   = 11'(pal_nodes - 2);
        r.suffix_len = 11'(pal_len[clip_node(tail_node)]);
        r.created    = created;
        r.ovf        = ovf;
        return r;
    endfunction

    function automatic t_tree_result tree_extend(logic [4:0] letter);
        int cur;
        int kid;
        int fresh;
        if (text_len >= MAX_TEXT) return tree_status(1'b0, 1'b1);
        if (letter >= ALPHABET) return tree_status(1'b0, 1'b0);
        text_mem[text_len] = letter;
        text_len++;
        cur = find_extendable(tail_node, letter);
        kid = pal_child[cur * ALPHABET + letter];
        if (kid != 0) begin
            tail_node = clip_node(kid);
            return tree_status(1'b0, 1'b0);
        end
        fresh = clip_node(pal_nodes);
        pal_len[fresh] = pal_len[cur] + 2;
        pal_child[cur * ALPHABET + letter] = fresh;
        pal_nodes++;
        if (pal_len[fresh] == 1) begin
            pal_link[fresh] = 1;
        end else begin
            cur = find_extendable(pal_link[cur], letter);
            pal_link[fresh] = pal_child[cur * ALPHABET + letter];
        end
        tail_node = fresh;
        return tree_status(1'b1, 1'b0);
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", beats_out, field, got, want);
        errors++;
    endtask

    // phase of idling follows how far the stimulus has got
    function automatic void set_phase(int item);
        if (item < 350) begin
            send_idle_pct = 38;
            recv_idle_pct = 80;
        end else if (item < 700) begin
            send_idle_pct = 80;
            recv_idle_pct = 38;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    task automatic send_letter(logic [4:0] letter, bit typed, t_tree_result typed_res);
        t_tree_result p;
        set_phase(beats_in);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_letter <= letter;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        p = tree_extend(letter);
        pending_results.push_back(typed ? typed_res : p);
        beats_in++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || draining) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(negedge i_clk) begin
        t_tree_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result beat %0d", beats_out);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_distinct_palindromes != want.distinct)
                    report_mismatch("distinct", o_distinct_palindromes, want.distinct);
                if (o_longest_suffix_length != want.suffix_len)
                    report_mismatch("suffix_len", o_longest_suffix_length, want.suffix_len);
                if (o_created_new != want.created)
                    report_mismatch("created", o_created_new, want.created);
                if (o_overflow != want.ovf)
                    report_mismatch("overflow", o_overflow, want.ovf);
                nodes_made += want.created;
                overflows  += want.ovf;
            end
            beats_out++;
        end
    end

    function automatic t_stim_row row(logic [4:0] l, bit typed, int d, int s, bit c, bit o);
        t_stim_row r;
        r.letter = l;
        r.typed = typed;
        r.res = '{distinct: 11'(d), suffix_len: 11'(s), created: c, ovf: o};
        return r;
    endfunction

    initial begin
        t_stim_row   directed[$];
        logic [4:0]  chunk[$];
        int          alpha;
        int          half;
        int          mode;
        int          tail_items;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_letter = '0;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        nodes_made = 0;
        overflows = 0;
        draining = 1'b0;
        set_phase(0);
        tree_reset();

        directed.push_back(row(5'd31, 1, 0, 0, 0, 0));
        directed.push_back(row(5'd0,  1, 1, 1, 1, 0));
        directed.push_back(row(5'd0,  1, 2, 2, 1, 0));
        directed.push_back(row(5'd26, 1, 2, 2, 0, 0));
        directed.push_back(row(5'd0,  1, 3, 3, 1, 0));
        directed.push_back(row(5'd25, 1, 4, 1, 1, 0));
        directed.push_back(row(5'd0,  0, 0, 0, 0, 0));
        directed.push_back(row(5'd0,  0, 0, 0, 0, 0));
        directed.push_back(row(5'd0,  0, 0, 0, 0, 0));
        directed.push_back(row(5'd25, 0, 0, 0, 0, 0));
        directed.push_back(row(5'd16, 0, 0, 0, 0, 0));
        directed.push_back(row(5'd25, 0, 0, 0, 0, 0));
        directed.push_back(row(5'd0,  0, 0, 0, 0, 0));
        directed.push_back(row(5'd15, 0, 0, 0, 0, 0));
        directed.push_back(row(5'd30, 0, 0, 0, 0, 0));
        directed.push_back(row(5'd1,  0, 0, 0, 0, 0));
        directed.push_back(row(5'd1,  0, 0, 0, 0, 0));
        directed.push_back(row(5'd15, 0, 0, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_letter(directed[k].letter, directed[k].typed, directed[k].res);

        // palindromic chunks over small alphabets, plain runs, and out-of-range noise
        tail_items = 0;
        while (tail_items < 12) begin
            mode  = $urandom_range(9);
            alpha = ($urandom_range(9) == 0) ? ALPHABET : $urandom_range(4, 1);
            chunk.delete();
            if (mode < 6) begin
                half = $urandom_range(10);
                for (int j = 0; j < half; j++) chunk.push_back(5'($urandom_range(alpha - 1)));
                if ($urandom_range(1)) chunk.push_back(5'($urandom_range(alpha - 1)));
                for (int j = half - 1; j >= 0; j--) chunk.push_back(chunk[j]);
            end else if (mode < 9) begin
                repeat ($urandom_range(12, 1)) chunk.push_back(5'($urandom_range(alpha - 1)));
            end else begin
                chunk.push_back(5'($urandom_range(31, ALPHABET)));
            end
            foreach (chunk[j]) begin
                if (text_len >= MAX_TEXT) tail_items++;
                send_letter(chunk[j], 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        wait (pending_results.size() == 0);
        draining = 1'b1;
        repeat (300) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("covered %0d letters, %0d results, %0d nodes created, %0d overflow beats",
                 beats_in, beats_out, nodes_made, overflows);
        $display("text filled to %0d letters with three idling phases; %0d errors",
                 text_len, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/ptb_pkg.sv
hdl/ptb_front.sv
hdl/ptb_back.sv
hdl/palindromic_tree_builder.sv
hdl/ptb_checker.sv
verif/palindromic_tree_builder_tb.sv
